FILE: rtl/sfdc_pkg.sv
// ----------------------------------------------------------------------------
// sfdc_pkg
// Shared constants and types for the serial frame deframer with checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package sfdc_pkg;

    localparam int MAX_PAYLOAD = 256;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 9;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = $clog2(MAX_PAYLOAD + 10);
    localparam int TDATA_W = ((BYTE_W + POS_W + 7) / 8) * 8;
    localparam int TUSER_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

    localparam logic [CNT_W-1:0] POS_HUNT      = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_SYNC_SEEN = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_BODY      = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_LEN_HI    = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_LEN_LO    = CNT_W'(7);

    // header, version, sequence, command, length and checksum bytes
    localparam logic [LEN_W:0] FRAME_OVERHEAD = (LEN_W + 1)'(9);
    localparam logic [LEN_W-1:0] LEN_LIMIT    = LEN_W'(MAX_PAYLOAD);

    typedef struct packed {
        logic              last_of_frame;
        logic              checksum_good;
        logic              length_error;
        logic [POS_W-1:0]  byte_position;
        logic [BYTE_W-1:0] frame_byte;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_beat_t;

endpackage

`default_nettype wire

FILE: rtl/sfdc_in_reg.sv
// ----------------------------------------------------------------------------
// sfdc_in_reg
// Input register stage: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdc_in_reg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [sfdc_pkg::BYTE_W-1:0] s_axis_tdata,   // rx_byte
    output sfdc_pkg::byte_beat_t           beat,
    input  wire logic                      beat_ready
);
    import sfdc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    assign s_axis_tready = !valid_reg || beat_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_axis_tready) begin
            valid_next = s_axis_tvalid;
            data_next  = s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/sfdc_core.sv
// ----------------------------------------------------------------------------
// sfdc_core
// Frame state, length and checksum checks, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdc_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sfdc_pkg::byte_beat_t beat,
    output logic                      beat_ready,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output sfdc_pkg::result_t         res
);
    import sfdc_pkg::*;

    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [CNT_W-1:0]  frame_total_reg;
    logic [CNT_W-1:0]  frame_total_next;
    logic [BYTE_W-1:0] length_high_byte_reg;
    logic [BYTE_W-1:0] length_high_byte_next;
    logic [BYTE_W-1:0] running_sum_reg;
    logic [BYTE_W-1:0] running_sum_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           out_next;

    logic              take;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  length;
    logic [CNT_W-1:0]  total_eff;
    logic              hunt;

    assign beat_ready = !out_valid_reg || res_ready;
    assign take       = beat.valid && beat_ready;
    assign b          = beat.data;
    assign length     = {length_high_byte_reg, b};

    always_comb begin
        fill_count_next       = fill_count_reg;
        frame_total_next      = frame_total_reg;
        length_high_byte_next = length_high_byte_reg;
        running_sum_next      = running_sum_reg;
        out_valid_next        = out_valid_reg && !res_ready;
        out_next              = out_reg;
        total_eff             = frame_total_reg;
        hunt                  = 1'b0;

        if (take) begin
            if (fill_count_reg == POS_HUNT) begin
                if (b == SYNC_FIRST) begin
                    fill_count_next  = POS_SYNC_SEEN;
                    running_sum_next = SYNC_FIRST;
                end
            end else if (fill_count_reg == POS_SYNC_SEEN) begin
                if (b == SYNC_SECOND) begin
                    fill_count_next  = POS_BODY;
                    running_sum_next = SYNC_FIRST + SYNC_SECOND;
                end else if (b == SYNC_FIRST) begin
                    running_sum_next = SYNC_FIRST;
                end else begin
                    hunt = 1'b1;
                end
            end else begin
                out_valid_next             = 1'b1;
                out_next.frame_byte        = b;
                out_next.byte_position     = POS_W'(fill_count_reg);
                out_next.last_of_frame     = 1'b0;
                out_next.checksum_good     = 1'b0;
                out_next.length_error      = 1'b0;

                if (fill_count_reg == POS_LEN_HI) begin
                    length_high_byte_next = b;
                end

                if (fill_count_reg == POS_LEN_LO && length > LEN_LIMIT) begin
                    out_next.last_of_frame = 1'b1;
                    out_next.length_error  = 1'b1;
                    hunt                   = 1'b1;
                end else begin
                    if (fill_count_reg == POS_LEN_LO) begin
                        total_eff = CNT_W'({1'b0, length} + FRAME_OVERHEAD);
                    end
                    if (total_eff != '0 && fill_count_reg == total_eff - CNT_W'(1)) begin
                        out_next.last_of_frame = 1'b1;
                        out_next.checksum_good = (running_sum_reg == b);
                        hunt                   = 1'b1;
                    end else begin
                        running_sum_next = running_sum_reg + b;
                        fill_count_next  = fill_count_reg + CNT_W'(1);
                        frame_total_next = total_eff;
                    end
                end
            end

            if (hunt) begin
                fill_count_next       = POS_HUNT;
                frame_total_next      = '0;
                length_high_byte_next = '0;
                running_sum_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg       <= POS_HUNT;
            frame_total_reg      <= '0;
            length_high_byte_reg <= '0;
            running_sum_reg      <= '0;
            out_valid_reg        <= 1'b0;
        end else begin
            fill_count_reg       <= fill_count_next;
            frame_total_reg      <= frame_total_next;
            length_high_byte_reg <= length_high_byte_next;
            running_sum_reg      <= running_sum_next;
            out_valid_reg        <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

FILE: rtl/serial_frame_deframer_checksum_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_checksum_unit
// Hunts the 0x55 0xAA header in a received byte stream and passes on every
// later frame byte with its position, length error and checksum flags.
// ----------------------------------------------------------------------------
// channel  direction  payload
// s_axis   in         tdata = rx_byte
// m_axis   out        tdata = frame_byte, byte_position; tlast = last_of_frame;
//                     tuser = checksum_good, length_error
//
// one byte per cycle sustained while m_axis takes every result; a byte that
// yields a result passes through the input register, then the result register,
// before it appears on m_axis
// header bytes give no result transfer
// reset is synchronous, active low, and returns the block to header hunting
// a stall on m_axis holds the result register and backs up through the input
// register only when both are full
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_deframer_checksum_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [sfdc_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [sfdc_pkg::TDATA_W-1:0]       m_axis_tdata,   // frame_byte, byte_position
    output logic                               m_axis_tlast,   // last_of_frame
    output logic [sfdc_pkg::TUSER_W-1:0]       m_axis_tuser    // checksum_good, length_error
);
    import sfdc_pkg::*;

    byte_beat_t beat;
    logic       beat_ready;
    result_t    res;

    sfdc_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .beat          (beat),
        .beat_ready    (beat_ready)
    );

    sfdc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (beat),
        .beat_ready (beat_ready),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = TDATA_W'({res.byte_position, res.frame_byte});
    assign m_axis_tlast = res.last_of_frame;
    assign m_axis_tuser = {res.length_error, res.checksum_good};

endmodule

`default_nettype wire

FILE: tb/tb_serial_frame_deframer_checksum_unit.sv
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_checksum_unit
// Feeds received bytes into the deframer and checks every output transfer
// against a cycle-free model of header hunting, length limit and checksum.
// The model keeps its own queue of expected frame bytes. A short directed
// sequence comes first, then random frames, broken frames and line noise,
// under three settings of sender and receiver stalls, the last without stalls.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_checksum_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sfdc_pkg::*;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    class deframe_scoreboard;
        logic [POS_W:0]    hdr_fill;
        logic [LEN_W:0]    frame_len;
        logic [BYTE_W-1:0] len_hi;
        logic [BYTE_W-1:0] byte_sum;
        result_t           pending_results[$];
        int unsigned       mismatches;

        function new();
            mismatches = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            hdr_fill  = '0;
            frame_len = '0;
            len_hi    = '0;
            byte_sum  = '0;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function void note_rx_byte(logic [BYTE_W-1:0] b);
            result_t        r;
            logic [LEN_W:0] plen;
            logic [POS_W:0] pos;
            if (hdr_fill == 0) begin
                if (b == SYNC_FIRST) begin
                    hdr_fill = (POS_W + 1)'(1);
                    byte_sum = SYNC_FIRST;
                end
                return;
            end
            if (hdr_fill == 1) begin
                if (b == SYNC_SECOND) begin
                    hdr_fill = (POS_W + 1)'(2);
                    byte_sum = SYNC_FIRST + SYNC_SECOND;
                end else if (b == SYNC_FIRST) begin
                    byte_sum = SYNC_FIRST;
                end else begin
                    restart_hunt();
                end
                return;
            end
            pos = hdr_fill;
            r = '0;
            r.frame_byte = b;
            r.byte_position = pos[POS_W-1:0];
            if (pos == 6)
                len_hi = b;
            if (pos == 7) begin
                plen = {1'b0, len_hi, b};
                if (plen > MAX_PAYLOAD) begin
                    r.last_of_frame = 1'b1;
                    r.length_error = 1'b1;
                    pending_results.push_back(r);
                    restart_hunt();
                    return;
                end
                frame_len = plen + (LEN_W + 1)'(9);
            end
            if (frame_len != 0 && (LEN_W + 1)'(pos) == frame_len - 1'b1) begin
                r.last_of_frame = 1'b1;
                r.checksum_good = (byte_sum == b);
                pending_results.push_back(r);
                restart_hunt();
                return;
            end
            byte_sum = byte_sum + b;
            hdr_fill = pos + 1'b1;
            pending_results.push_back(r);
        endfunction

        function void check_frame_byte(logic [TDATA_W-1:0] tdata, logic tlast,
                                       logic [TUSER_W-1:0] tuser);
            result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: byte %h pos %0d last %b user %b",
                             tdata[7:0], tdata[16:8], tlast, tuser);
                return;
            end
            want = pending_results.pop_front();
            if (tdata[7:0] !== want.frame_byte || tdata[16:8] !== want.byte_position ||
                tlast !== want.last_of_frame || tuser[0] !== want.checksum_good ||
                tuser[1] !== want.length_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected byte %h pos %0d last %b good %b lerr %b,",
                             want.frame_byte, want.byte_position, want.last_of_frame,
                             want.checksum_good, want.length_error,
                             " got byte %h pos %0d last %b good %b lerr %b",
                             tdata[7:0], tdata[16:8], tlast, tuser[0], tuser[1]);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata;    // [7:0] rx_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [TDATA_W-1:0]  m_axis_tdata;    // [7:0] frame_byte, [16:8] byte_position
    logic                m_axis_tlast;    // last_of_frame
    logic [TUSER_W-1:0]  m_axis_tuser;    // [0] checksum_good, [1] length_error

    deframe_scoreboard sb;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       rx_sent;

    serial_frame_deframer_checksum_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_sent = 0;
        sb = new();
    end

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_axis_tready = aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_frame_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_rx_byte(s_axis_tdata);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = BYTE_W'($urandom);
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        rx_sent++;
    endtask

    task automatic send_seq(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    task automatic send_frame(input int unsigned plen, input bit bad_sum,
                              input int unsigned cut_len);
        byte_q_t           q;
        logic [LEN_W-1:0]  len16;
        logic [BYTE_W-1:0] acc;
        len16 = plen[LEN_W-1:0];
        q = {SYNC_FIRST, SYNC_SECOND};
        repeat (4)
            q.push_back(BYTE_W'($urandom));
        q.push_back(len16[15:8]);
        q.push_back(len16[7:0]);
        if (plen <= MAX_PAYLOAD) begin
            repeat (plen)
                q.push_back(BYTE_W'($urandom));
            acc = '0;
            foreach (q[i])
                acc += q[i];
            q.push_back(bad_sum ? acc + BYTE_W'($urandom_range(1, 255)) : acc);
        end
        if (cut_len != 0 && cut_len < q.size())
            q = q[0:cut_len-1];
        send_seq(q);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                             input int unsigned stop_at, input bit with_extremes);
        int unsigned pick;
        int unsigned plen;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (with_extremes) begin
            send_frame(MAX_PAYLOAD, 1'b0, 0);
            send_frame(MAX_PAYLOAD + 1, 1'b0, 0);
        end
        while (rx_sent < stop_at) begin
            pick = $urandom_range(99);
            plen = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (pick < 70) begin
                send_frame(plen, $urandom_range(3) == 0, 0);
            end else if (pick < 76) begin
                send_frame($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF), 1'b0, 0);
            end else if (pick < 84) begin
                send_frame(plen, 1'b0, $urandom_range(1, plen + 8));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom));
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 62;
        // wrong second header byte, then a repeated first byte before the header
        send_seq({8'h55, 8'h12, 8'h55, 8'h55, 8'hAA});
        // zero length, checksum right at position 8
        send_seq({8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFD});
        // length just above the limit
        send_seq({8'h55, 8'hAA, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h01});
        // one payload byte, wrong checksum
        send_seq({8'h55, 8'hAA, 8'h01, 8'h12, 8'h34, 8'h80, 8'h00, 8'h01, 8'hFF, 8'h00});
        wait_drained();

        run_phase(35, 62, 480, 1'b0);
        run_phase(62, 35, 940, 1'b0);
        run_phase(0, 0, 1400, 1'b1);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule
